// ===== sv/tgsb_pkg.sv =====
`default_nettype none

package tgsb_pkg;

  localparam int unsigned PcWidth   = 17;
  localparam int unsigned IvWidth   = 63;
  localparam int unsigned TimeWidth = 64;
  localparam int unsigned IdxWidth  = 16;
  localparam int unsigned ProdWidth = PcWidth + IvWidth;
  localparam int unsigned QuoWidth  = IdxWidth;
  localparam int unsigned DivWidth  = IvWidth + QuoWidth;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 64;

  localparam logic [PcWidth-1:0] MinPoints = PcWidth'(2);
  localparam logic [PcWidth-1:0] MaxPoints = PcWidth'(65536);

  localparam logic RegIdxPointCount = 1'b0;
  localparam logic RegIdxInterval   = 1'b1;

  typedef enum logic [1:0] {
    KindBad,
    KindLow,
    KindHigh,
    KindDiv
  } kind_e;

  typedef struct packed {
    logic signed [TimeWidth-1:0] elapsed_time;
  } in_item_t;

  typedef struct packed {
    logic                bracket_ok;
    logic [IdxWidth-1:0] lower_point;
    logic [IdxWidth-1:0] upper_point;
    logic [IvWidth-1:0]  fraction_numerator;
    logic [IvWidth-1:0]  fraction_denominator;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/tgsb_if.sv =====
`default_nettype none

interface tgsb_in_if;
  import tgsb_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tgsb_out_if;
  import tgsb_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/time_grid_segment_bracket_core.sv =====
// pipeline: 20 register stages from input to output
// throughput: one transaction per cycle, through the pipelined 16-stage restoring divider
//   (one quotient bit per stage); a stall on the output holds every stage
// reset: rst_ni clears all valid bits and both configuration registers
`default_nettype none

module time_grid_segment_bracket_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tgsb_in_if.sink                        in_i,
  tgsb_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tgsb_pkg::AddrWidth-1:0] paddr,
  input  logic [tgsb_pkg::DataWidth-1:0] pwdata,
  output logic [tgsb_pkg::DataWidth-1:0] prdata,
  output logic                           pready
);
  import tgsb_pkg::*;

  localparam int unsigned DivStages = QuoWidth;
  localparam int unsigned PlWidth   = PcWidth + 32;
  localparam int unsigned PhWidth   = PcWidth + IvWidth - 32;

  logic [PcWidth-1:0] pc_q;
  logic [IvWidth-1:0] iv_q;
  logic               wr_en;

  logic adv;

  logic                 s1_vld_q;
  logic [TimeWidth-1:0] s1_raw_q;
  logic [PlWidth-1:0]   s1_plo_q;
  logic [PhWidth-1:0]   s1_phi_q;
  logic [PlWidth-1:0]   s1_plo_d;
  logic [PhWidth-1:0]   s1_phi_d;

  logic                 s2_vld_q;
  logic [TimeWidth-1:0] s2_raw_q;
  logic [ProdWidth-1:0] s2_prod_q;
  logic                 s2_bad_q;
  logic [ProdWidth-1:0] s2_prod_d;
  logic                 s2_bad_d;
  logic [PcWidth-1:0]   last_pts;

  kind_e                s3_kind_d;

  logic                dv_vld_q  [0:DivStages];
  logic [IvWidth-1:0]  dv_rem_q  [0:DivStages];
  logic [QuoWidth-1:0] dv_quo_q  [0:DivStages];
  kind_e               dv_kind_q [0:DivStages];

  logic [DivWidth-1:0] dv_sh   [1:DivStages];
  logic [DivWidth-1:0] dv_ext  [1:DivStages];
  logic                dv_ge   [1:DivStages];

  logic      out_vld_q;
  out_item_t out_data_q;
  out_item_t out_d;

  // configuration port

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
      iv_q <= '0;
    end else if (wr_en) begin
      unique case (paddr[AddrWidth-1])
        RegIdxPointCount: pc_q <= pwdata[PcWidth-1:0];
        RegIdxInterval:   iv_q <= pwdata[IvWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[AddrWidth-1])
      RegIdxPointCount: prdata = DataWidth'(pc_q);
      RegIdxInterval:   prdata = DataWidth'(iv_q);
      default:          prdata = '0;
    endcase
  end

  // pipeline control

  assign adv         = !out_vld_q || out_o.ready;
  assign in_i.ready  = adv;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_data_q;

  // stage 1: partial products of the terminal offset

  assign last_pts = pc_q - PcWidth'(1);
  assign s1_plo_d = PlWidth'(last_pts) * PlWidth'(iv_q[31:0]);
  assign s1_phi_d = PhWidth'(last_pts) * PhWidth'(iv_q[IvWidth-1:32]);

  // stage 2: terminal offset and config check

  assign s2_prod_d = ProdWidth'(s1_plo_q) + (ProdWidth'(s1_phi_q) << 32);
  assign s2_bad_d  = (pc_q < MinPoints) || (iv_q == '0) || (pc_q > MaxPoints);

  // stage 3: classify

  always_comb begin
    if (s2_bad_q || (s2_prod_q[ProdWidth-1:IvWidth] != '0)) begin
      s3_kind_d = KindBad;
    end else if ((s2_raw_q == '0) || s2_raw_q[TimeWidth-1]) begin
      s3_kind_d = KindLow;
    end else if (s2_raw_q[IvWidth-1:0] >= s2_prod_q[IvWidth-1:0]) begin
      s3_kind_d = KindHigh;
    end else begin
      s3_kind_d = KindDiv;
    end
  end

  // restoring divider, one quotient bit per stage

  always_comb begin
    for (int i = 1; i <= DivStages; i++) begin
      dv_sh[i]  = DivWidth'(iv_q) << (DivStages - i);
      dv_ext[i] = DivWidth'(dv_rem_q[i-1]);
      dv_ge[i]  = dv_ext[i] >= dv_sh[i];
    end
  end

  // result assembly

  always_comb begin
    out_d = '0;
    case (dv_kind_q[DivStages])
      KindLow: begin
        out_d.bracket_ok           = 1'b1;
        out_d.fraction_denominator = iv_q;
      end
      KindHigh: begin
        out_d.bracket_ok           = 1'b1;
        out_d.lower_point          = IdxWidth'(pc_q - PcWidth'(2));
        out_d.upper_point          = IdxWidth'(last_pts);
        out_d.fraction_numerator   = iv_q;
        out_d.fraction_denominator = iv_q;
      end
      KindDiv: begin
        out_d.bracket_ok           = 1'b1;
        out_d.fraction_denominator = iv_q;
        if (dv_rem_q[DivStages] == '0) begin
          out_d.lower_point        = dv_quo_q[DivStages] - IdxWidth'(1);
          out_d.upper_point        = dv_quo_q[DivStages];
          out_d.fraction_numerator = iv_q;
        end else begin
          out_d.lower_point        = dv_quo_q[DivStages];
          out_d.upper_point        = dv_quo_q[DivStages] + IdxWidth'(1);
          out_d.fraction_numerator = dv_rem_q[DivStages];
        end
      end
      default: out_d = '0;
    endcase
  end

  // valid bits

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i <= DivStages; i++) begin
        dv_vld_q[i] <= 1'b0;
      end
    end else if (adv) begin
      s1_vld_q    <= in_i.valid;
      s2_vld_q    <= s1_vld_q;
      dv_vld_q[0] <= s2_vld_q;
      for (int i = 1; i <= DivStages; i++) begin
        dv_vld_q[i] <= dv_vld_q[i-1];
      end
      out_vld_q   <= dv_vld_q[DivStages];
    end
  end

  // payload

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_raw_q     <= in_i.data.elapsed_time;
      s1_plo_q     <= s1_plo_d;
      s1_phi_q     <= s1_phi_d;
      s2_raw_q     <= s1_raw_q;
      s2_prod_q    <= s2_prod_d;
      s2_bad_q     <= s2_bad_d;
      dv_rem_q[0]  <= s2_raw_q[IvWidth-1:0];
      dv_quo_q[0]  <= '0;
      dv_kind_q[0] <= s3_kind_d;
      for (int i = 1; i <= DivStages; i++) begin
        dv_rem_q[i]  <= dv_ge[i] ? IvWidth'(dv_ext[i] - dv_sh[i]) : dv_rem_q[i-1];
        dv_quo_q[i]  <= {dv_quo_q[i-1][QuoWidth-2:0], dv_ge[i]};
        dv_kind_q[i] <= dv_kind_q[i-1];
      end
      out_data_q   <= out_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tgsb_checker.sv =====
`default_nettype none

module tgsb_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  tgsb_pkg::out_item_t out_data_i,
  input  logic                pready_i
);
  import tgsb_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // a result with bracket_ok low has every field clear
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.bracket_ok |->
      out_data_i.lower_point == '0 && out_data_i.upper_point == '0 &&
      out_data_i.fraction_numerator == '0 && out_data_i.fraction_denominator == '0)
    else $error("invalid bracket with nonzero fields");

  // segment is either the start point or two neighbors
  a_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.bracket_ok |->
      (out_data_i.upper_point == out_data_i.lower_point + IdxWidth'(1)) ||
      (out_data_i.upper_point == '0 && out_data_i.lower_point == '0 &&
       out_data_i.fraction_numerator == '0))
    else $error("bad segment indices");

  // fraction stays within the segment
  a_fraction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.bracket_ok |->
      out_data_i.fraction_denominator != '0 &&
      out_data_i.fraction_numerator <= out_data_i.fraction_denominator)
    else $error("fraction out of range");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("pready low");

endmodule

bind time_grid_segment_bracket_core tgsb_checker u_tgsb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data),
  .pready_i    (pready)
);

`default_nettype wire
